// ===== rtl/core/srsj_pkg.sv =====
// shared types and constants for the step response settle judge
package srsj_pkg;

  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_POLL   = 2'd1;
  localparam logic [1:0] MODE_CANCEL = 2'd2;

  localparam logic [2:0] ST_SETTLED     = 3'd0;
  localparam logic [2:0] ST_NEVER       = 3'd1;
  localparam logic [2:0] ST_LOST        = 3'd2;
  localparam logic [2:0] ST_NO_MOVE     = 3'd3;
  localparam logic [2:0] ST_TOO_FEW     = 3'd4;
  localparam logic [2:0] ST_TOO_FAST    = 3'd5;

  localparam logic [2:0] REG_SETTLE_BAND = 3'd0;
  localparam logic [2:0] REG_HOLD_TIME   = 3'd1;
  localparam logic [2:0] REG_TRIAL_CAP   = 3'd2;
  localparam logic [2:0] REG_OVS_WEIGHT  = 3'd3;
  localparam logic [2:0] REG_MIN_OBS     = 3'd4;
  localparam logic [2:0] REG_MIN_SETTLE  = 3'd5;
  localparam logic [2:0] REG_MIN_START   = 3'd6;

  localparam logic [11:0] SETTLE_BAND_RST = 12'd96;
  localparam logic [19:0] HOLD_TIME_RST   = 20'd70000;
  localparam logic [23:0] TRIAL_CAP_RST   = 24'd1400000;
  localparam logic [11:0] OVS_WEIGHT_RST  = 12'd750;
  localparam logic [7:0]  MIN_OBS_RST     = 8'd4;
  localparam logic [19:0] MIN_SETTLE_RST  = 20'd8000;
  localparam logic [14:0] MIN_START_RST   = 15'd784;
  localparam logic [23:0] BAND_SQ_RST     = 24'd9216;
  localparam logic [29:0] START_SQ_RST    = 30'd614656;

  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic        valid;
    logic [2:0]  status;
    logic [23:0] settle_us;
    logic [15:0] overshoot;
  } result_t;

endpackage

// ===== rtl/core/step_response_settle_judge_top.sv =====
// step response settle judge: trial tracking, settle and overshoot judgment
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid / in_ready     | mode elapsed_us err_x err_y has_target stamp
//  out     | output    | out_valid / out_ready   | status settle_us overshoot score
//  cfg     | input     | apb psel/penable/pready | paddr pwdata prdata
//
// four register stages: input word, squared radius, trial state and result, score.
// one word per cycle unless held; a word that closes or rejects a trial yields a result word.
// the whole pipeline holds while a result waits on out_ready; in_ready is then low.
// rst (synchronous) clears the trial state and restores the register defaults.
module step_response_settle_judge_top
  import srsj_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input words
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [23:0]        elapsed_us,
  input  logic signed [15:0] err_x,
  input  logic signed [15:0] err_y,
  input  logic               has_target,
  input  logic [15:0]        stamp,
  // result words
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [23:0]        settle_us,
  output logic [15:0]        overshoot,
  output logic [27:0]        score,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // configuration registers
  logic [11:0] settle_band;
  logic [19:0] hold_time_us;
  logic [23:0] trial_cap_us;
  logic [11:0] overshoot_weight;
  logic [7:0]  min_observations;
  logic [19:0] min_settle_us;
  logic [14:0] min_start_error;
  logic [23:0] band_sq;
  logic [29:0] start_sq;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_band      <= SETTLE_BAND_RST;
      hold_time_us     <= HOLD_TIME_RST;
      trial_cap_us     <= TRIAL_CAP_RST;
      overshoot_weight <= OVS_WEIGHT_RST;
      min_observations <= MIN_OBS_RST;
      min_settle_us    <= MIN_SETTLE_RST;
      min_start_error  <= MIN_START_RST;
      band_sq          <= BAND_SQ_RST;
      start_sq         <= START_SQ_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SETTLE_BAND: begin
          settle_band <= pwdata[11:0];
          band_sq     <= 24'(pwdata[11:0]) * 24'(pwdata[11:0]);
        end
        REG_HOLD_TIME:  hold_time_us     <= pwdata[19:0];
        REG_TRIAL_CAP:  trial_cap_us     <= pwdata[23:0];
        REG_OVS_WEIGHT: overshoot_weight <= pwdata[11:0];
        REG_MIN_OBS:    min_observations <= pwdata[7:0];
        REG_MIN_SETTLE: min_settle_us    <= pwdata[19:0];
        REG_MIN_START: begin
          min_start_error <= pwdata[14:0];
          start_sq        <= 30'(pwdata[14:0]) * 30'(pwdata[14:0]);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SETTLE_BAND: prdata = {20'd0, settle_band};
      REG_HOLD_TIME:   prdata = {12'd0, hold_time_us};
      REG_TRIAL_CAP:   prdata = {8'd0, trial_cap_us};
      REG_OVS_WEIGHT:  prdata = {20'd0, overshoot_weight};
      REG_MIN_OBS:     prdata = {24'd0, min_observations};
      REG_MIN_SETTLE:  prdata = {12'd0, min_settle_us};
      REG_MIN_START:   prdata = {17'd0, min_start_error};
      default:         prdata = 32'd0;
    endcase
  end

  // whole pipeline advances together
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 1: input word
  logic               s1_valid;
  logic [1:0]         s1_mode;
  logic [23:0]        s1_elapsed;
  logic signed [15:0] s1_ex;
  logic signed [15:0] s1_ey;
  logic               s1_target;
  logic [15:0]        s1_stamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
    if (adv) begin
      s1_mode    <= mode;
      s1_elapsed <= elapsed_us;
      s1_ex      <= err_x;
      s1_ey      <= err_y;
      s1_target  <= has_target;
      s1_stamp   <= stamp;
    end
  end

  // stage 2: squared radius
  logic [16:0] ax;
  logic [16:0] ay;
  logic [31:0] ax_sq;
  logic [31:0] ay_sq;

  assign ax    = s1_ex[15] ? 17'(-{s1_ex[15], s1_ex}) : {1'b0, s1_ex};
  assign ay    = s1_ey[15] ? 17'(-{s1_ey[15], s1_ey}) : {1'b0, s1_ey};
  assign ax_sq = 32'(ax) * 32'(ax);
  assign ay_sq = 32'(ay) * 32'(ay);

  logic               s2_valid;
  logic [1:0]         s2_mode;
  logic [23:0]        s2_elapsed;
  logic signed [15:0] s2_ex;
  logic               s2_target;
  logic [15:0]        s2_stamp;
  logic [31:0]        s2_r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
    if (adv) begin
      s2_mode    <= s1_mode;
      s2_elapsed <= s1_elapsed;
      s2_ex      <= s1_ex;
      s2_target  <= s1_target;
      s2_stamp   <= s1_stamp;
      // max radius squared is 2^31, fits 32 bits
      s2_r2      <= ax_sq + ay_sq;
    end
  end

  // stage 3: trial state and judgment
  logic        running;
  logic        push_negative;
  logic [15:0] peak_past;
  logic        inside_valid;
  logic [23:0] inside_since_us;
  logic [7:0]  observation_count;
  logic [15:0] last_stamp;

  logic        running_next;
  logic        push_negative_next;
  logic [15:0] peak_past_next;
  logic        inside_valid_next;
  logic [23:0] inside_since_us_next;
  logic [7:0]  observation_count_next;
  logic [15:0] last_stamp_next;
  result_t     res;
  result_t     s3_res;

  function automatic result_t judge(input logic settled, input logic [23:0] t,
                                    input logic [7:0] cnt, input logic [15:0] peak,
                                    input logic [7:0] min_obs,
                                    input logic [19:0] min_settle,
                                    input logic [23:0] cap);
    result_t r;
    r.valid = 1'b1;
    if (cnt < min_obs) begin
      r.status    = ST_TOO_FEW;
      r.settle_us = 24'd0;
      r.overshoot = 16'd0;
    end else if (settled && (t < {4'd0, min_settle})) begin
      r.status    = ST_TOO_FAST;
      r.settle_us = 24'd0;
      r.overshoot = 16'd0;
    end else begin
      r.status    = settled ? ST_SETTLED : ST_NEVER;
      r.settle_us = settled ? t : cap;
      r.overshoot = peak;
    end
    return r;
  endfunction

  logic signed [16:0] past;
  logic [7:0]         cnt_inc;
  logic [23:0]        held;

  assign past    = push_negative ? {s2_ex[15], s2_ex} : 17'(-{s2_ex[15], s2_ex});
  assign cnt_inc = (observation_count < COUNT_MAX) ? 8'(observation_count + 8'd1)
                                                   : observation_count;
  assign held    = 24'(s2_elapsed - inside_since_us);

  always_comb begin
    running_next           = running;
    push_negative_next     = push_negative;
    peak_past_next         = peak_past;
    inside_valid_next      = inside_valid;
    inside_since_us_next   = inside_since_us;
    observation_count_next = observation_count;
    last_stamp_next        = last_stamp;
    res                    = '0;
    if (s2_valid) begin
      if (s2_mode == MODE_START) begin
        running_next = 1'b0;
        if (!s2_target) begin
          res.valid  = 1'b1;
          res.status = ST_LOST;
        end else if (s2_r2 < {2'd0, start_sq}) begin
          res.valid  = 1'b1;
          res.status = ST_NO_MOVE;
        end else begin
          running_next           = 1'b1;
          push_negative_next     = s2_ex[15];
          peak_past_next         = 16'd0;
          inside_valid_next      = 1'b0;
          inside_since_us_next   = 24'd0;
          observation_count_next = 8'd0;
          last_stamp_next        = 16'd0;
        end
      end else if (running) begin
        if (s2_mode == MODE_CANCEL) begin
          running_next = 1'b0;
          res = judge(1'b0, 24'd0, observation_count, peak_past, min_observations,
                      min_settle_us, trial_cap_us);
        end else if (s2_mode == MODE_POLL) begin
          if (s2_elapsed > trial_cap_us) begin
            running_next = 1'b0;
            res = judge(1'b0, 24'd0, observation_count, peak_past, min_observations,
                        min_settle_us, trial_cap_us);
          end else if (s2_target && (s2_stamp != last_stamp)) begin
            last_stamp_next        = s2_stamp;
            observation_count_next = cnt_inc;
            if ((past > 17'sd0) && (past[15:0] > peak_past)) begin
              peak_past_next = past[15:0];
            end
            if (s2_r2 <= {8'd0, band_sq}) begin
              if (!inside_valid) begin
                inside_valid_next    = 1'b1;
                inside_since_us_next = s2_elapsed;
              end else if ((s2_elapsed >= inside_since_us) &&
                           (held >= {4'd0, hold_time_us}) &&
                           (cnt_inc >= min_observations)) begin
                running_next = 1'b0;
                res = judge(1'b1, inside_since_us, cnt_inc, peak_past_next,
                            min_observations, min_settle_us, trial_cap_us);
              end
            end else begin
              inside_valid_next    = 1'b0;
              inside_since_us_next = 24'd0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running           <= 1'b0;
      push_negative     <= 1'b0;
      peak_past         <= 16'd0;
      inside_valid      <= 1'b0;
      inside_since_us   <= 24'd0;
      observation_count <= 8'd0;
      last_stamp        <= 16'd0;
      s3_res            <= '0;
    end else if (adv) begin
      running           <= running_next;
      push_negative     <= push_negative_next;
      peak_past         <= peak_past_next;
      inside_valid      <= inside_valid_next;
      inside_since_us   <= inside_since_us_next;
      observation_count <= observation_count_next;
      last_stamp        <= last_stamp_next;
      s3_res            <= res;
    end
  end

  // stage 4: score and result word
  logic [27:0] ovs_prod;
  assign ovs_prod = 28'(s3_res.overshoot) * 28'(overshoot_weight);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s3_res.valid;
    end
    if (adv) begin
      status    <= s3_res.status;
      settle_us <= s3_res.settle_us;
      overshoot <= s3_res.overshoot;
      score     <= 28'(ovs_prod + {4'd0, s3_res.settle_us});
    end
  end

endmodule

// ===== sim/tb_step_response_settle_judge_top.sv =====
// testbench for the step response settle judge: directed and random trials, scoreboard check
module tb_step_response_settle_judge_top;
  import srsj_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [23:0] elapsed;
    logic [15:0] ex;
    logic [15:0] ey;
    logic        tgt;
    logic [15:0] stamp;
  } trial_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [23:0] settle;
    logic [15:0] ovs;
    logic [27:0] score;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = '0;
  logic [23:0] elapsed_us = '0;
  logic [15:0] err_x = '0;
  logic [15:0] err_y = '0;
  logic        has_target = 1'b0;
  logic [15:0] stamp = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [23:0] settle_us;
  logic [15:0] overshoot;
  logic [27:0] score;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] cfg_rdata;
  logic        pready;

  // predictor copy of the registers
  logic [11:0] cfg_band = SETTLE_BAND_RST;
  logic [19:0] cfg_hold = HOLD_TIME_RST;
  logic [23:0] cfg_cap = TRIAL_CAP_RST;
  logic [11:0] cfg_weight = OVS_WEIGHT_RST;
  logic [7:0]  cfg_min_obs = MIN_OBS_RST;
  logic [19:0] cfg_min_settle = MIN_SETTLE_RST;
  logic [14:0] cfg_min_start = MIN_START_RST;

  // predictor copy of the trial state
  bit          trial_live = 1'b0;
  bit          push_neg = 1'b0;
  logic [15:0] peak_travel = '0;
  bit          in_band = 1'b0;
  logic [23:0] band_entry_us = '0;
  logic [7:0]  obs_count = '0;
  logic [15:0] last_seen_stamp = '0;

  // expected result words, written at input accept and read at output accept
  verdict_t verdict_ring[64];
  logic [5:0] ring_wr = '0;
  logic [5:0] ring_rd = '0;
  verdict_t head;
  int mismatches = 0;
  int words_sent = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  logic [15:0] next_stamp = '0;

  step_response_settle_judge_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .elapsed_us(elapsed_us), .err_x(err_x), .err_y(err_y),
    .has_target(has_target), .stamp(stamp),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .settle_us(settle_us), .overshoot(overshoot), .score(score),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(cfg_rdata), .pready(pready)
  );

  always #2 clk = ~clk;

  function automatic bit close_trial(input bit settled, input logic [23:0] entry,
                                     output verdict_t v);
    logic [23:0] t;
    v = '0;
    trial_live = 1'b0;
    if (obs_count < cfg_min_obs) begin
      v.status = ST_TOO_FEW;
      return 1'b1;
    end
    if (settled && entry < cfg_min_settle) begin
      v.status = ST_TOO_FAST;
      return 1'b1;
    end
    t = settled ? entry : cfg_cap;
    v.status = settled ? ST_SETTLED : ST_NEVER;
    v.settle = t;
    v.ovs = peak_travel;
    v.score = 28'(t) + 28'(peak_travel) * 28'(cfg_weight);
    return 1'b1;
  endfunction

  // returns 1 when the word closes or rejects a trial
  function automatic bit judge_word(input trial_word_t w, output verdict_t v);
    longint sx;
    longint sy;
    longint r2;
    longint past;
    v = '0;
    sx = longint'($signed(w.ex));
    sy = longint'($signed(w.ey));
    r2 = sx * sx + sy * sy;
    if (w.mode == MODE_START) begin
      trial_live = 1'b0;
      if (!w.tgt) begin
        v.status = ST_LOST;
        return 1'b1;
      end
      if (r2 < longint'(cfg_min_start) * longint'(cfg_min_start)) begin
        v.status = ST_NO_MOVE;
        return 1'b1;
      end
      trial_live = 1'b1;
      push_neg = sx < 0;
      peak_travel = '0;
      in_band = 1'b0;
      band_entry_us = '0;
      obs_count = '0;
      last_seen_stamp = '0;
      return 1'b0;
    end
    if (!trial_live) return 1'b0;
    if (w.mode == MODE_CANCEL) return close_trial(1'b0, '0, v);
    if (w.mode != MODE_POLL) return 1'b0;
    // cap is checked before the error is looked at
    if (w.elapsed > cfg_cap) return close_trial(1'b0, '0, v);
    if (!w.tgt || w.stamp == last_seen_stamp) return 1'b0;
    last_seen_stamp = w.stamp;
    if (obs_count != COUNT_MAX) obs_count = obs_count + 8'd1;
    past = push_neg ? sx : -sx;
    if (past > 0 && past > longint'(peak_travel)) peak_travel = past[15:0];
    if (r2 <= longint'(cfg_band) * longint'(cfg_band)) begin
      if (!in_band) begin
        in_band = 1'b1;
        band_entry_us = w.elapsed;
      end else if (w.elapsed >= band_entry_us && w.elapsed - band_entry_us >= cfg_hold &&
                   obs_count >= cfg_min_obs) begin
        return close_trial(1'b1, band_entry_us, v);
      end
    end else begin
      in_band = 1'b0;
      band_entry_us = '0;
    end
    return 1'b0;
  endfunction

  function automatic trial_word_t word_of(input logic [1:0] m, input int t, input int x,
                                          input int y, input bit tgt, input int s);
    trial_word_t w;
    w.mode = m;
    w.elapsed = 24'(t);
    w.ex = 16'(x);
    w.ey = 16'(y);
    w.tgt = tgt;
    w.stamp = 16'(s);
    return w;
  endfunction

  function automatic trial_word_t noise_word();
    trial_word_t w;
    w.mode = 2'($urandom);
    w.elapsed = 24'($urandom);
    w.ex = 16'($urandom);
    w.ey = 16'($urandom);
    w.tgt = 1'($urandom);
    w.stamp = 16'($urandom);
    return w;
  endfunction

  function automatic logic [15:0] rand_s16(input int mag);
    int v;
    if (mag > 32767) mag = 32767;
    v = int'($urandom_range(2 * mag)) - mag;
    return v[15:0];
  endfunction

  task automatic send_word(input trial_word_t w);
    verdict_t v;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= w.mode;
    elapsed_us <= w.elapsed;
    err_x <= w.ex;
    err_y <= w.ey;
    has_target <= w.tgt;
    stamp <= w.stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (judge_word(w, v)) begin
      verdict_ring[ring_wr] = v;
      ring_wr = ring_wr + 6'd1;
    end
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (ring_rd != ring_wr) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SETTLE_BAND: cfg_band = val[11:0];
      REG_HOLD_TIME:   cfg_hold = val[19:0];
      REG_TRIAL_CAP:   cfg_cap = val[23:0];
      REG_OVS_WEIGHT:  cfg_weight = val[11:0];
      REG_MIN_OBS:     cfg_min_obs = val[7:0];
      REG_MIN_SETTLE:  cfg_min_settle = val[19:0];
      REG_MIN_START:   cfg_min_start = val[14:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic cfg_apply(input int band, input int hold, input int cap, input int wt,
                           input int min_obs, input int min_settle, input int min_start);
    cfg_write(REG_SETTLE_BAND, band);
    cfg_write(REG_HOLD_TIME, hold);
    cfg_write(REG_TRIAL_CAP, cap);
    cfg_write(REG_OVS_WEIGHT, wt);
    cfg_write(REG_MIN_OBS, min_obs);
    cfg_write(REG_MIN_SETTLE, min_settle);
    cfg_write(REG_MIN_START, min_start);
  endtask

  // one start word, a decaying run of polls with random flaws, then a cancel or over-cap poll
  task automatic run_trial();
    trial_word_t w;
    int t;
    int step;
    int polls;
    int settle_at;
    int mag;
    int amp;
    int r;
    logic [15:0] prev_stamp;
    mag = $urandom_range(32767, cfg_min_start);
    w = '0;
    w.mode = MODE_START;
    w.elapsed = 24'($urandom);
    w.tgt = ($urandom_range(15) != 0);
    w.stamp = 16'($urandom);
    if ($urandom_range(15) == 0) begin
      w.ex = rand_s16(cfg_min_start / 2);
      w.ey = rand_s16(cfg_min_start / 2);
    end else begin
      w.ex = $urandom_range(1) ? 16'(-mag) : 16'(mag);
      w.ey = rand_s16(mag / 4);
    end
    send_word(w);
    t = $urandom_range(2000);
    step = cfg_hold / 3 + 200;
    polls = $urandom_range(60, 4);
    settle_at = $urandom_range(8);
    prev_stamp = '0;
    for (int i = 0; i < polls && trial_live; i++) begin
      r = $urandom_range(99);
      w = '0;
      if (r < 3) begin
        w = noise_word();
      end else if (r < 5) begin
        w = word_of(MODE_START, $urandom, $urandom_range(1) ? -mag : mag, 0, 1'b1, 0);
      end else begin
        w.mode = MODE_POLL;
        t += $urandom_range(step);
        // time going backwards now and then
        if (r < 9) t -= $urandom_range(step + 1000);
        if (t < 0) t = 0;
        if (t > 24'hFFFFFF) t = 24'hFFFFFF;
        w.elapsed = 24'(t);
        w.tgt = !(r >= 9 && r < 13);
        if (r >= 13 && r < 18) begin
          w.stamp = prev_stamp;
        end else begin
          next_stamp = next_stamp + 16'd1;
          if (next_stamp == 16'd0) next_stamp = 16'd1;
          w.stamp = next_stamp;
        end
        prev_stamp = w.stamp;
        if (i < settle_at || r >= 95) begin
          amp = (mag >> i) + cfg_band + 1;
          w.ex = rand_s16(amp);
          w.ey = rand_s16(amp / 2);
        end else begin
          w.ex = rand_s16(cfg_band / 2);
          w.ey = rand_s16(cfg_band / 2);
        end
      end
      send_word(w);
    end
    if (trial_live) begin
      if (cfg_cap != 24'hFFFFFF && $urandom_range(1))
        w = word_of(MODE_POLL, cfg_cap + 1, $urandom, $urandom, 1'($urandom), $urandom);
      else
        w = word_of(MODE_CANCEL, $urandom, $urandom, $urandom, 1'($urandom), $urandom);
      send_word(w);
    end
  endtask

  task automatic run_words(input int n);
    int goal;
    goal = words_sent + n;
    while (words_sent < goal) begin
      if ($urandom_range(99) < 4) send_word(noise_word());
      else run_trial();
    end
  endtask

  // reset register values
  task automatic test_directed_cases();
    send_word(word_of(MODE_START, 0, 2000, 2000, 1'b0, 0));
    send_word(word_of(MODE_START, 0, 100, 100, 1'b1, 0));
    send_word(word_of(MODE_POLL, 100, 0, 0, 1'b1, 1));
    send_word(word_of(MODE_CANCEL, 0, 0, 0, 1'b1, 2));
    send_word(word_of(MODE_NONE, 0, 0, 0, 1'b1, 3));
    // push toward negative x, overshoot shows as positive x
    send_word(word_of(MODE_START, 0, -32768, 32767, 1'b1, 0));
    send_word(word_of(MODE_POLL, 1000, 500, 0, 1'b1, 0));
    send_word(word_of(MODE_POLL, 2000, 300, 0, 1'b1, 1));
    send_word(word_of(MODE_POLL, 2500, 10, 0, 1'b1, 1));
    send_word(word_of(MODE_POLL, 3000, 10, 0, 1'b0, 2));
    send_word(word_of(MODE_POLL, 10000, 10, -10, 1'b1, 3));
    send_word(word_of(MODE_POLL, 5000, 0, 0, 1'b1, 4));
    send_word(word_of(MODE_POLL, 90000, -5, 5, 1'b1, 5));
    // restart while running drops the first trial
    send_word(word_of(MODE_START, 0, 0, -800, 1'b1, 0));
    send_word(word_of(MODE_START, 0, 32767, -32768, 1'b1, 0));
    send_word(word_of(MODE_POLL, 100, -32768, 32767, 1'b1, 65535));
    send_word(word_of(MODE_POLL, 200, 2000, 0, 1'b1, 8));
    send_word(word_of(MODE_POLL, 300, 2000, 0, 1'b1, 9));
    send_word(word_of(MODE_POLL, 400, 2000, 0, 1'b1, 10));
    send_word(word_of(MODE_POLL, 24'hFFFFFF, 0, 0, 1'b1, 11));
    // settles too early
    send_word(word_of(MODE_START, 0, 800, 0, 1'b1, 0));
    send_word(word_of(MODE_POLL, 1000, 0, 0, 1'b1, 1));
    send_word(word_of(MODE_POLL, 2000, 0, 0, 1'b1, 2));
    send_word(word_of(MODE_POLL, 3000, 0, 0, 1'b1, 3));
    send_word(word_of(MODE_POLL, 71000, 0, 0, 1'b1, 4));
    send_word(word_of(MODE_START, 0, -900, 5, 1'b1, 0));
    send_word(word_of(MODE_CANCEL, 0, 0, 0, 1'b0, 0));
    wait_idle();
  endtask

  task automatic test_min_obs_zero();
    cfg_write(REG_MIN_OBS, 0);
    send_word(word_of(MODE_START, 0, 1000, 0, 1'b1, 0));
    send_word(word_of(MODE_CANCEL, 0, 0, 0, 1'b1, 0));
    send_word(word_of(MODE_START, 0, -1000, 0, 1'b1, 0));
    send_word(word_of(MODE_POLL, 0, 1, 1, 1'b1, 1));
    send_word(word_of(MODE_POLL, 70000, 1, 1, 1'b1, 2));
    wait_idle();
  endtask

  // count has to stop at its top or the cancel below reports too few
  task automatic test_count_saturation();
    cfg_write(REG_MIN_OBS, COUNT_MAX);
    send_word(word_of(MODE_START, 0, -2000, 0, 1'b1, 0));
    for (int i = 1; i <= 300; i++) send_word(word_of(MODE_POLL, i * 10, 2000, 0, 1'b1, i));
    send_word(word_of(MODE_CANCEL, 0, 0, 0, 1'b1, 0));
    wait_idle();
  endtask

  task automatic test_random_settings(input int n);
    cfg_apply($urandom_range(600, 8), $urandom_range(30000), $urandom_range(3000000, 200000),
              $urandom_range(4095), $urandom_range(12, 1), $urandom_range(20000),
              $urandom_range(4000));
    run_words(n);
    wait_idle();
  endtask

  task automatic test_extreme_high(input int n);
    cfg_apply(4095, 1048575, 16777215, 4095, 255, 1048575, 32767);
    run_words(n);
    wait_idle();
  endtask

  task automatic test_extreme_low(input int n);
    cfg_apply(0, 0, 1, 0, 1, 0, 0);
    run_words(n);
    wait_idle();
  endtask

  // receiver stops for a long stretch while words keep coming
  task automatic test_backpressure();
    hold_seq <= hold_seq + 1;
    run_words(80);
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (ring_rd == ring_wr) begin
        $error("result word with nothing pending: status %0d settle_us %0d", status, settle_us);
        mismatches++;
      end else begin
        head = verdict_ring[ring_rd];
        ring_rd = ring_rd + 6'd1;
        if (status !== head.status) begin
          $error("status expected %0d got %0d", head.status, status);
          mismatches++;
        end
        if (settle_us !== head.settle) begin
          $error("settle_us expected %0d got %0d", head.settle, settle_us);
          mismatches++;
        end
        if (overshoot !== head.ovs) begin
          $error("overshoot expected %0d got %0d", head.ovs, overshoot);
          mismatches++;
        end
        if (score !== head.score) begin
          $error("score expected %0d got %0d", head.score, score);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    tx_idle_pct = 9;
    rx_idle_pct = 81;
    test_directed_cases();
    test_min_obs_zero();
    test_count_saturation();
    test_random_settings(400);
    tx_idle_pct = 81;
    rx_idle_pct = 9;
    test_extreme_high(150);
    test_random_settings(300);
    test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_extreme_low(150);
    test_random_settings(300);
    test_backpressure();
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
